// ===== sv/swhs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the single-wire humidity sensor decoder.
// No dependencies.
package swhs_pkg;

  localparam int unsigned TimeW   = 8;
  localparam int unsigned DataW   = 40;
  localparam int unsigned CountW  = 6;
  localparam int unsigned HumW    = 16;
  localparam int unsigned TempW   = 16;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CountW-1:0] DATA_BITS = CountW'(DataW);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_WAIT = 3'd1,
    PH_RECV = 3'd2,
    PH_DONE = 3'd3,
    PH_TERR = 3'd4,
    PH_CERR = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    FN_START   = 2'd0,
    FN_EDGE    = 2'd1,
    FN_TIMEOUT = 2'd2,
    FN_NONE    = 2'd3
  } func_t;

  localparam logic [CfgIdxW-1:0] REG_RESP_MIN = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_RESP_MAX = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BIT_MIN  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BIT_MAX  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ONE_THR  = 3'd4;

  localparam logic [TimeW-1:0] RESP_MIN_RST = 8'd130;
  localparam logic [TimeW-1:0] RESP_MAX_RST = 8'd200;
  localparam logic [TimeW-1:0] BIT_MIN_RST  = 8'd60;
  localparam logic [TimeW-1:0] BIT_MAX_RST  = 8'd200;
  localparam logic [TimeW-1:0] ONE_THR_RST  = 8'd90;

  typedef struct packed {
    logic [TimeW-1:0] resp_min;
    logic [TimeW-1:0] resp_max;
    logic [TimeW-1:0] bit_min;
    logic [TimeW-1:0] bit_max;
    logic [TimeW-1:0] one_thr;
  } cfg_t;

  typedef struct packed {
    phase_t                  status;
    logic [HumW-1:0]         humidity;
    logic signed [TempW-1:0] temperature;
  } result_t;

endpackage

// ===== sv/single_wire_humidity_sensor_decoder_top.sv =====
`timescale 1ns / 1ps
// Decodes a single-wire humidity sensor reply from edge intervals. One item
// is accepted per cycle unless the input is stalled, and each item gives one
// result item: the item is captured in an input register, the decode stage
// updates the reading state and loads the result register. Throughput is one
// item per clock while the output is not stalled.
// Top level: handshake, configuration registers, input and result registers.
// Depends on swhs_pkg and swhs_dec.
module single_wire_humidity_sensor_decoder_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_func,
  input  logic [swhs_pkg::TimeW-1:0]        in_interval_us,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        out_status,
  output logic [swhs_pkg::HumW-1:0]         out_humidity,
  output logic signed [swhs_pkg::TempW-1:0] out_temperature,
  input  logic                              cfg_we,
  input  logic [swhs_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [swhs_pkg::TimeW-1:0]        cfg_wdata
);

  swhs_pkg::cfg_t                   cfg_r;
  logic                             s1_valid_r;
  logic [1:0]                       s1_func_r;
  logic [swhs_pkg::TimeW-1:0]       s1_interval_r;
  logic                             out_valid_r;
  swhs_pkg::result_t                res_r;
  swhs_pkg::result_t                res_nxt;
  logic                             adv;
  logic                             fire;
  logic                             in_take;

  assign adv     = !(out_valid_r && out_stall);
  assign fire    = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;
  assign in_take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.resp_min <= swhs_pkg::RESP_MIN_RST;
      cfg_r.resp_max <= swhs_pkg::RESP_MAX_RST;
      cfg_r.bit_min  <= swhs_pkg::BIT_MIN_RST;
      cfg_r.bit_max  <= swhs_pkg::BIT_MAX_RST;
      cfg_r.one_thr  <= swhs_pkg::ONE_THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        swhs_pkg::REG_RESP_MIN: cfg_r.resp_min <= cfg_wdata;
        swhs_pkg::REG_RESP_MAX: cfg_r.resp_max <= cfg_wdata;
        swhs_pkg::REG_BIT_MIN:  cfg_r.bit_min  <= cfg_wdata;
        swhs_pkg::REG_BIT_MAX:  cfg_r.bit_max  <= cfg_wdata;
        swhs_pkg::REG_ONE_THR:  cfg_r.one_thr  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_func_r     <= in_func;
      s1_interval_r <= in_interval_us;
    end
  end

  swhs_dec u_dec (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .func        (s1_func_r),
    .interval_us (s1_interval_r),
    .cfg         (cfg_r),
    .res         (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = res_r.status;
  assign out_humidity    = res_r.humidity;
  assign out_temperature = res_r.temperature;

  a_data_zero_unless_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.status != swhs_pkg::PH_DONE) |->
      (res_r.humidity == '0) && (res_r.temperature == '0))
    else $error("result data nonzero without done status");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled with free pipeline");

  a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without an item in the input register");

endmodule

// ===== sv/swhs_dec.sv =====
`timescale 1ns / 1ps
// Decode stage: phase, received word and bit count, with the next result.
// Depends on swhs_pkg.
module swhs_dec (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [1:0]                  func,
  input  logic [swhs_pkg::TimeW-1:0]  interval_us,
  input  swhs_pkg::cfg_t              cfg,
  output swhs_pkg::result_t           res
);

  swhs_pkg::phase_t                 phase_r, phase_nxt;
  logic [swhs_pkg::DataW-1:0]       bits_r, bits_nxt;
  logic [swhs_pkg::CountW-1:0]      count_r, count_nxt;

  logic [swhs_pkg::DataW-1:0]       shifted;
  logic [swhs_pkg::CountW-1:0]      count_inc;
  logic [7:0]                       sum8;
  logic                             resp_ok, bit_ok, bit_val;
  logic [7:0]                       b0, b1, b2, b3;
  logic [14:0]                      mag;
  logic [swhs_pkg::TempW-1:0]       temp;

  assign resp_ok   = (interval_us >= cfg.resp_min) && (interval_us <= cfg.resp_max);
  assign bit_ok    = (interval_us >= cfg.bit_min) && (interval_us <= cfg.bit_max);
  assign bit_val   = interval_us > cfg.one_thr;
  assign shifted   = {bits_r[swhs_pkg::DataW-2:0], bit_val};
  assign count_inc = swhs_pkg::CountW'(count_r + 1'b1);
  assign sum8      = 8'(shifted[39:32] + shifted[31:24] + shifted[23:16] + shifted[15:8]);

  always_comb begin
    phase_nxt = phase_r;
    bits_nxt  = bits_r;
    count_nxt = count_r;
    case (swhs_pkg::func_t'(func))
      swhs_pkg::FN_START: begin
        bits_nxt  = '0;
        count_nxt = '0;
        phase_nxt = swhs_pkg::PH_WAIT;
      end
      swhs_pkg::FN_EDGE: begin
        if (phase_r == swhs_pkg::PH_WAIT) begin
          phase_nxt = resp_ok ? swhs_pkg::PH_RECV : swhs_pkg::PH_TERR;
        end else if (phase_r == swhs_pkg::PH_RECV) begin
          if (!bit_ok) begin
            phase_nxt = swhs_pkg::PH_TERR;
          end else begin
            bits_nxt  = shifted;
            count_nxt = count_inc;
            if (count_inc >= swhs_pkg::DATA_BITS) begin
              phase_nxt = (sum8 == shifted[7:0]) ? swhs_pkg::PH_DONE : swhs_pkg::PH_CERR;
            end
          end
        end
      end
      swhs_pkg::FN_TIMEOUT: begin
        if (phase_r == swhs_pkg::PH_WAIT || phase_r == swhs_pkg::PH_RECV) begin
          phase_nxt = swhs_pkg::PH_TERR;
        end
      end
      default: begin
      end
    endcase
  end

  // byte 0 is the first received, in the top bits
  assign b0   = bits_nxt[39:32];
  assign b1   = bits_nxt[31:24];
  assign b2   = bits_nxt[23:16];
  assign b3   = bits_nxt[15:8];
  assign mag  = {b2[6:0], b3};
  assign temp = b2[7] ? (16'd0 - {1'b0, mag}) : {1'b0, mag};

  always_comb begin
    res.status = phase_nxt;
    if (phase_nxt == swhs_pkg::PH_DONE) begin
      res.humidity    = {b0, b1};
      res.temperature = temp;
    end else begin
      res.humidity    = '0;
      res.temperature = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= swhs_pkg::PH_IDLE;
      bits_r  <= '0;
      count_r <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      bits_r  <= bits_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
